[src/ihx_pkg.sv]
// ----------------------------------------------------------------------------
// ihx_pkg: shared types and constants for the Intel HEX stream decoder
// Character token format, record phases, action and result kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ihx_pkg;

  // Depth of the token queue between classifier and decoder
  localparam int QUEUE_DEPTH = 4;

  localparam int LINE_NUMBER_BITS_DEFAULT = 16;

  // Input actions
  localparam logic [1:0] ACT_CHAR    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_END     = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_DATA       = 3'd0;
  localparam logic [2:0] KIND_OK         = 3'd1;
  localparam logic [2:0] KIND_END        = 3'd2;
  localparam logic [2:0] KIND_FINISHED   = 3'd3;
  localparam logic [2:0] KIND_BAD_START  = 3'd4;
  localparam logic [2:0] KIND_BAD_RECORD = 3'd5;
  localparam logic [2:0] KIND_BAD_DATA   = 3'd6;
  localparam logic [2:0] KIND_CHECKSUM   = 3'd7;

  // Record types of interest
  localparam logic [7:0] REC_DATA  = 8'h00;
  localparam logic [7:0] REC_EOF   = 8'h01;
  localparam logic [7:0] REC_UPPER = 8'h04;
  localparam logic [7:0] UPPER_LEN = 8'h02;

  // Characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNT,
    PH_OFFSET,
    PH_TYPE,
    PH_DATA,
    PH_CHECK,
    PH_TRAIL,
    PH_HALT
  } phase_t;

  // Classified input transaction
  typedef struct packed {
    logic [1:0] action;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_blank;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
  } token_t;

endpackage

`default_nettype wire

[src/ihx_front.sv]
// ----------------------------------------------------------------------------
// ihx_front: character classifier
// Turns each incoming transaction into a token and pushes it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ihx_front (
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // character
  input  wire logic [1:0]    s_tuser,   // action
  input  wire logic          q_full,
  output logic               q_push,
  output ihx_pkg::token_t    q_token
);

  logic [7:0] c;

  assign c        = s_tdata;
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_token.action   = s_tuser;
    q_token.is_hex   = 1'b0;
    q_token.hex_val  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      q_token.is_hex  = 1'b1;
      q_token.hex_val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      // 'A'..'F' and 'a'..'f': low nibble 1..6 maps to 10..15
      q_token.is_hex  = 1'b1;
      q_token.hex_val = c[3:0] + 4'd9;
    end
    q_token.is_blank = (c == ihx_pkg::CH_SPACE) || (c == ihx_pkg::CH_TAB) ||
                       (c == ihx_pkg::CH_VT) || (c == ihx_pkg::CH_FF);
    q_token.is_cr    = (c == ihx_pkg::CH_CR);
    q_token.is_lf    = (c == ihx_pkg::CH_LF);
    q_token.is_colon = (c == ihx_pkg::CH_COLON);
  end

endmodule

`default_nettype wire

[src/ihx_queue.sv]
// ----------------------------------------------------------------------------
// ihx_queue: token queue
// Small FIFO that decouples the classifier from the record decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module ihx_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ihx_pkg::token_t push_token,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output ihx_pkg::token_t      head
);

  localparam int DEPTH = ihx_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  ihx_pkg::token_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/ihx_back.sv]
// ----------------------------------------------------------------------------
// ihx_back: record decoder
// Runs the record state machine on one token per cycle whenever its output
// register is empty or being taken, and holds the result in that register.
// ----------------------------------------------------------------------------
`default_nettype none

module ihx_back #(
  parameter int LINE_NUMBER_BITS = ihx_pkg::LINE_NUMBER_BITS_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire ihx_pkg::token_t q_head,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [55:0]          m_tdata,   // address[31:0], data_byte, line_number
  output logic [2:0]           m_tuser    // kind
);

  localparam int LNB = LINE_NUMBER_BITS;
  localparam logic [LNB-1:0] LN_CAP = {LNB{1'b1}};

  ihx_pkg::phase_t phase, phase_next;
  logic [7:0]     record_length, record_length_next;
  logic [15:0]    record_offset, record_offset_next;
  logic [7:0]     record_type, record_type_next;
  logic [7:0]     running_sum, running_sum_next;
  logic [3:0]     high_nibble, high_nibble_next;
  logic           nibble_pending, nibble_pending_next;
  logic [7:0]     data_index, data_index_next;
  logic [15:0]    upper_address, upper_address_next;
  logic [15:0]    pending_upper, pending_upper_next;
  logic           bad_data_seen, bad_data_seen_next;
  logic           bad_check_digit, bad_check_digit_next;
  logic [LNB-1:0] line_counter, line_counter_next;
  logic           last_was_cr, last_was_cr_next;
  logic           finished, finished_next;

  // decode of the current token
  logic        go, stopped, in_record, in_header;
  logic        ch_go, lf_skip, is_eol, plain;
  logic        restart_ev, end_ev, eol_ev, idle_ev, start_ev, bad_start;
  logic        rec_ev, bad_hdr, dig_ev, byte_ev;
  logic        data_ev, check_ev, upper_rec;
  logic        bad_data_eff, bad_check_eff, check_fail, eol_fail, end_fail, fail_ev;
  logic        data_emit;
  logic [3:0]  v;
  logic [7:0]  b;
  logic [7:0]  sum_new;
  logic [8:0]  idx_inc;
  logic [31:0] data_addr;

  // result
  logic           res_valid;
  logic [2:0]     res_kind;
  logic [31:0]    res_addr;
  logic [7:0]     res_byte;
  logic [LNB-1:0] ln_sat;
  logic [LNB+15:0] ln_ext;

  assign go      = q_valid && (!m_tvalid || m_tready);
  assign q_pop   = go;
  assign stopped = (phase == ihx_pkg::PH_HALT) || finished;
  assign in_header = (phase == ihx_pkg::PH_COUNT) || (phase == ihx_pkg::PH_OFFSET) ||
                     (phase == ihx_pkg::PH_TYPE);
  assign in_record = in_header || (phase == ihx_pkg::PH_DATA) ||
                     (phase == ihx_pkg::PH_CHECK);

  assign restart_ev = go && (q_head.action == ihx_pkg::ACT_RESTART);
  assign end_ev     = go && (q_head.action == ihx_pkg::ACT_END) && !stopped;
  assign ch_go      = go && (q_head.action == ihx_pkg::ACT_CHAR) && !stopped;
  assign lf_skip    = q_head.is_lf && last_was_cr;
  assign is_eol     = q_head.is_cr || q_head.is_lf;
  assign plain      = ch_go && !lf_skip && !is_eol;

  assign eol_ev     = ch_go && !lf_skip && is_eol;
  assign idle_ev    = plain && (phase == ihx_pkg::PH_IDLE);
  assign start_ev   = idle_ev && q_head.is_colon;
  assign bad_start  = idle_ev && !q_head.is_blank && !q_head.is_colon;
  assign rec_ev     = plain && in_record;
  assign bad_hdr    = rec_ev && !q_head.is_hex && (q_head.is_blank || in_header);
  assign dig_ev     = rec_ev && !bad_hdr;
  assign byte_ev    = dig_ev && nibble_pending;

  assign v       = q_head.is_hex ? q_head.hex_val : 4'd0;
  assign b       = {high_nibble, v};
  assign sum_new = running_sum + b;
  assign idx_inc = {1'b0, data_index} + 9'd1;

  assign upper_rec = (record_type == ihx_pkg::REC_UPPER) &&
                     (record_length == ihx_pkg::UPPER_LEN);
  // a bad digit in this very byte counts right away
  assign bad_data_eff  = bad_data_seen ||
                         (dig_ev && (phase == ihx_pkg::PH_DATA) && !q_head.is_hex);
  assign bad_check_eff = bad_check_digit ||
                         (dig_ev && (phase == ihx_pkg::PH_CHECK) && !q_head.is_hex);

  assign data_ev    = byte_ev && (phase == ihx_pkg::PH_DATA);
  assign check_ev   = byte_ev && (phase == ihx_pkg::PH_CHECK);
  assign check_fail = check_ev && (bad_data_eff || bad_check_eff || (sum_new != 8'd0));
  assign eol_fail   = eol_ev && in_record;
  assign end_fail   = end_ev && in_record;
  assign fail_ev    = bad_start || bad_hdr || eol_fail || end_fail || check_fail;
  assign data_emit  = data_ev && (record_type == ihx_pkg::REC_DATA) && !bad_data_eff;
  assign data_addr  = {upper_address, 16'h0000} + {16'h0000, record_offset} +
                      {24'h000000, data_index};

  // next phase
  always_comb begin
    phase_next = phase;
    if (restart_ev) begin
      phase_next = ihx_pkg::PH_IDLE;
    end else if (fail_ev) begin
      phase_next = ihx_pkg::PH_HALT;
    end else if (eol_ev) begin
      phase_next = ihx_pkg::PH_IDLE;
    end else if (start_ev) begin
      phase_next = ihx_pkg::PH_COUNT;
    end else if (byte_ev) begin
      case (phase)
        ihx_pkg::PH_COUNT:  phase_next = ihx_pkg::PH_OFFSET;
        ihx_pkg::PH_OFFSET: begin
          if (data_index != 8'd0) phase_next = ihx_pkg::PH_TYPE;
        end
        ihx_pkg::PH_TYPE: begin
          phase_next = (record_length != 8'd0) ? ihx_pkg::PH_DATA : ihx_pkg::PH_CHECK;
        end
        ihx_pkg::PH_DATA: begin
          if (idx_inc >= {1'b0, record_length}) phase_next = ihx_pkg::PH_CHECK;
        end
        ihx_pkg::PH_CHECK:  phase_next = ihx_pkg::PH_TRAIL;
        default:            phase_next = phase;
      endcase
    end
  end

  // result outputs
  always_comb begin
    res_valid = 1'b1;
    res_kind  = ihx_pkg::KIND_OK;
    res_addr  = 32'd0;
    res_byte  = 8'd0;
    if (bad_start) begin
      res_kind = ihx_pkg::KIND_BAD_START;
    end else if (bad_hdr || eol_fail || end_fail) begin
      res_kind = ihx_pkg::KIND_BAD_RECORD;
    end else if (end_ev) begin
      res_kind = ihx_pkg::KIND_FINISHED;
    end else if (data_emit) begin
      res_kind = ihx_pkg::KIND_DATA;
      res_addr = data_addr;
      res_byte = b;
    end else if (check_ev) begin
      if (bad_data_eff) begin
        res_kind = ihx_pkg::KIND_BAD_DATA;
      end else if (check_fail) begin
        res_kind = ihx_pkg::KIND_CHECKSUM;
      end else if (record_type == ihx_pkg::REC_EOF) begin
        res_kind = ihx_pkg::KIND_END;
      end else begin
        res_kind = ihx_pkg::KIND_OK;
      end
    end else begin
      res_valid = 1'b0;
    end
  end

  // datapath next values
  always_comb begin
    record_length_next   = record_length;
    record_offset_next   = record_offset;
    record_type_next     = record_type;
    running_sum_next     = running_sum;
    high_nibble_next     = high_nibble;
    nibble_pending_next  = nibble_pending;
    data_index_next      = data_index;
    upper_address_next   = upper_address;
    pending_upper_next   = pending_upper;
    bad_data_seen_next   = bad_data_seen;
    bad_check_digit_next = bad_check_digit;
    line_counter_next    = line_counter;
    last_was_cr_next     = last_was_cr;
    finished_next        = finished;

    if (restart_ev) begin
      record_length_next   = 8'd0;
      record_offset_next   = 16'd0;
      record_type_next     = 8'd0;
      running_sum_next     = 8'd0;
      high_nibble_next     = 4'd0;
      nibble_pending_next  = 1'b0;
      data_index_next      = 8'd0;
      upper_address_next   = 16'd0;
      pending_upper_next   = 16'd0;
      bad_data_seen_next   = 1'b0;
      bad_check_digit_next = 1'b0;
      line_counter_next    = '0;
      last_was_cr_next     = 1'b0;
      finished_next        = 1'b0;
    end else begin
      if (ch_go) last_was_cr_next = q_head.is_cr;
      if (end_ev && !in_record) finished_next = 1'b1;
      if (eol_ev && !in_record && (line_counter != LN_CAP)) begin
        line_counter_next = line_counter + LNB'(1);
      end
      if (start_ev) begin
        record_length_next   = 8'd0;
        record_offset_next   = 16'd0;
        record_type_next     = 8'd0;
        running_sum_next     = 8'd0;
        high_nibble_next     = 4'd0;
        nibble_pending_next  = 1'b0;
        data_index_next      = 8'd0;
        pending_upper_next   = 16'd0;
        bad_data_seen_next   = 1'b0;
        bad_check_digit_next = 1'b0;
      end
      if (dig_ev) begin
        if (!q_head.is_hex && (phase == ihx_pkg::PH_DATA)) bad_data_seen_next = 1'b1;
        if (!q_head.is_hex && (phase == ihx_pkg::PH_CHECK)) bad_check_digit_next = 1'b1;
        if (!nibble_pending) begin
          high_nibble_next    = v;
          nibble_pending_next = 1'b1;
        end else begin
          nibble_pending_next = 1'b0;
          running_sum_next    = sum_new;
        end
      end
      if (byte_ev) begin
        case (phase)
          ihx_pkg::PH_COUNT: begin
            record_length_next = b;
            data_index_next    = 8'd0;
          end
          ihx_pkg::PH_OFFSET: begin
            record_offset_next = {record_offset[7:0], b};
            data_index_next    = (data_index == 8'd0) ? 8'd1 : 8'd0;
          end
          ihx_pkg::PH_TYPE: record_type_next = b;
          ihx_pkg::PH_DATA: begin
            data_index_next = idx_inc[7:0];
            if (upper_rec) pending_upper_next = {pending_upper[7:0], b};
          end
          ihx_pkg::PH_CHECK: begin
            if (!check_fail) begin
              if (record_type == ihx_pkg::REC_EOF) begin
                finished_next = 1'b1;
              end else if (upper_rec) begin
                upper_address_next = pending_upper;
              end
            end
          end
          default: record_type_next = record_type;
        endcase
      end
    end
  end

  // one-based line number, saturating, taken to 16 bits
  assign ln_sat = (line_counter == LN_CAP) ? LN_CAP : line_counter + LNB'(1);
  assign ln_ext = {16'h0000, ln_sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ihx_pkg::PH_IDLE;
      record_length   <= 8'd0;
      record_offset   <= 16'd0;
      record_type     <= 8'd0;
      running_sum     <= 8'd0;
      high_nibble     <= 4'd0;
      nibble_pending  <= 1'b0;
      data_index      <= 8'd0;
      upper_address   <= 16'd0;
      pending_upper   <= 16'd0;
      bad_data_seen   <= 1'b0;
      bad_check_digit <= 1'b0;
      line_counter    <= '0;
      last_was_cr     <= 1'b0;
      finished        <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      phase           <= phase_next;
      record_length   <= record_length_next;
      record_offset   <= record_offset_next;
      record_type     <= record_type_next;
      running_sum     <= running_sum_next;
      high_nibble     <= high_nibble_next;
      nibble_pending  <= nibble_pending_next;
      data_index      <= data_index_next;
      upper_address   <= upper_address_next;
      pending_upper   <= pending_upper_next;
      bad_data_seen   <= bad_data_seen_next;
      bad_check_digit <= bad_check_digit_next;
      line_counter    <= line_counter_next;
      last_was_cr     <= last_was_cr_next;
      finished        <= finished_next;
      if (go) begin
        m_tvalid <= res_valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      m_tdata <= {ln_ext[15:0], res_byte, res_addr};
      m_tuser <= res_kind;
    end
  end

endmodule

`default_nettype wire

[src/intel_hex_stream_decoder.sv]
// ----------------------------------------------------------------------------
// intel_hex_stream_decoder: Intel HEX text stream decoder
// Classifies characters, queues them and decodes records into data bytes,
// record outcomes and errors.
// ----------------------------------------------------------------------------
// The decoder takes one transaction per clock: a character, a restart or an
// end-of-stream marker, selected by s_tuser. It gives at most one result per
// input, in input order, on the m_ side. Data bytes (kind 0) come out as they
// are decoded and are tentative: commit them on "record ok" and drop them on
// any error kind. Once an error, an end record or end-of-stream is seen, all
// further characters and end markers give nothing until a restart, which
// clears every register, the upper address and the line count included.
// Throughput is one transaction per cycle sustained: the classifier accepts
// whenever the four-entry token queue has room, and the record decoder
// retires one token per cycle whenever its output register is empty or being
// taken. Line numbers count completed lines plus one and saturate at
// 2^LINE_NUMBER_BITS - 1 before being taken to 16 bits.
`default_nettype none

module intel_hex_stream_decoder #(
  parameter int LINE_NUMBER_BITS = ihx_pkg::LINE_NUMBER_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // character[7:0]
  input  wire logic [1:0]  s_tuser,   // action[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // address[31:0], data_byte[39:32], line_number[55:40]
  output logic [2:0]       m_tuser    // kind[2:0]
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  ihx_pkg::token_t push_token;
  ihx_pkg::token_t head_token;

  // front: classify each character
  ihx_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_token  (push_token)
  );

  // queue: lets front and back stall independently
  ihx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_token (push_token),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (head_token)
  );

  // back: record state machine and output register
  ihx_back #(
    .LINE_NUMBER_BITS (LINE_NUMBER_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (head_token),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

[tb/intel_hex_stream_decoder_test.sv]
// ----------------------------------------------------------------------------
// intel_hex_stream_decoder_test: self-checking bench for the HEX decoder
// Feeds character, restart, end and unused transactions built from
// well-formed, broken and noisy HEX lines. A scoreboard predicts every
// result and checks the result stream field by field, in order.
// ----------------------------------------------------------------------------
module intel_hex_stream_decoder_test;

  localparam int LINE_BITS = 16;
  localparam longint unsigned LINE_CAP = (64'd1 << LINE_BITS) - 1;
  // Cycles with no transaction on either side before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Cycles to linger after the last expected result.
  localparam int DRAIN_CYCLES = 20;
  // Spare action code: the block must leave all state alone.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Input transactions for the whole run, directed part included.
  localparam int ITEM_COUNT = 1350;
  // Closing stretch of the run with no idling on either side.
  localparam int QUIET_ITEMS = 200;

  // One predicted result, fields in m_tdata order plus kind
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [7:0]  data_byte;
    logic [15:0] line_number;
  } hex_result_t;

  // Predicts decoder results and compares them with the result stream.
  class hex_scoreboard;
    hex_result_t pending_results[$];
    int fail_count;

    ihx_pkg::phase_t ph;
    logic [7:0] rec_len;
    logic [15:0] rec_off;
    logic [7:0] rec_type;
    logic [7:0] sum;
    logic [3:0] hi_nib;
    bit have_hi;
    logic [7:0] byte_idx;
    logic [15:0] upper;
    logic [15:0] upper_next;
    bit bad_data;
    bit bad_check;
    longint unsigned lines_done;
    bit last_cr;
    bit done;

    function new();
      fail_count = 0;
      clear();
    endfunction

    function void clear();
      ph = ihx_pkg::PH_IDLE;
      rec_len = '0;
      rec_off = '0;
      rec_type = '0;
      sum = '0;
      hi_nib = '0;
      have_hi = 1'b0;
      byte_idx = '0;
      upper = '0;
      upper_next = '0;
      bad_data = 1'b0;
      bad_check = 1'b0;
      lines_done = 0;
      last_cr = 1'b0;
      done = 1'b0;
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == ihx_pkg::CH_SPACE || c == ihx_pkg::CH_TAB ||
             c == ihx_pkg::CH_VT || c == ihx_pkg::CH_FF;
    endfunction

    function bit report(logic [2:0] k, logic [31:0] a, logic [7:0] d, output hex_result_t r);
      longint unsigned ln;
      ln = lines_done + 1;
      if (ln > LINE_CAP) ln = LINE_CAP;
      r.kind = k;
      r.addr = a;
      r.data_byte = d;
      r.line_number = ln[15:0];
      return 1'b1;
    endfunction

    function bit halt_with(logic [2:0] k, output hex_result_t r);
      ph = ihx_pkg::PH_HALT;
      return report(k, '0, '0, r);
    endfunction

    // Advance the decoder by one transaction; returns 1 when a result is due.
    function bit decode_step(logic [1:0] act, logic [7:0] c, output hex_result_t r);
      bit in_rec;
      bit was_cr;
      int v;
      logic [7:0] b;
      int unsigned idx;
      r = '0;
      in_rec = (ph >= ihx_pkg::PH_COUNT) && (ph <= ihx_pkg::PH_CHECK);
      if (act == ihx_pkg::ACT_RESTART) begin
        clear();
        return 1'b0;
      end
      if (act == ihx_pkg::ACT_END) begin
        if (ph == ihx_pkg::PH_HALT || done) return 1'b0;
        if (in_rec) return halt_with(ihx_pkg::KIND_BAD_RECORD, r);
        done = 1'b1;
        return report(ihx_pkg::KIND_FINISHED, '0, '0, r);
      end
      if (act != ihx_pkg::ACT_CHAR || ph == ihx_pkg::PH_HALT || done) return 1'b0;

      was_cr = last_cr;
      last_cr = (c == ihx_pkg::CH_CR);
      if (c == ihx_pkg::CH_LF && was_cr) return 1'b0;
      if (c == ihx_pkg::CH_CR || c == ihx_pkg::CH_LF) begin
        if (in_rec) return halt_with(ihx_pkg::KIND_BAD_RECORD, r);
        if (lines_done < LINE_CAP) lines_done++;
        ph = ihx_pkg::PH_IDLE;
        return 1'b0;
      end
      if (ph == ihx_pkg::PH_IDLE) begin
        if (is_blank(c)) return 1'b0;
        if (c != ihx_pkg::CH_COLON) return halt_with(ihx_pkg::KIND_BAD_START, r);
        rec_len = '0;
        rec_off = '0;
        rec_type = '0;
        sum = '0;
        hi_nib = '0;
        have_hi = 1'b0;
        byte_idx = '0;
        upper_next = '0;
        bad_data = 1'b0;
        bad_check = 1'b0;
        ph = ihx_pkg::PH_COUNT;
        return 1'b0;
      end
      if (ph == ihx_pkg::PH_TRAIL) return 1'b0;

      v = hex_val(c);
      if (v < 0) begin
        if (is_blank(c) || ph <= ihx_pkg::PH_TYPE) return halt_with(ihx_pkg::KIND_BAD_RECORD, r);
        if (ph == ihx_pkg::PH_DATA) bad_data = 1'b1;
        else bad_check = 1'b1;
        v = 0;
      end
      if (!have_hi) begin
        hi_nib = v[3:0];
        have_hi = 1'b1;
        return 1'b0;
      end
      have_hi = 1'b0;
      b = {hi_nib, v[3:0]};
      sum = sum + b;

      case (ph)
        ihx_pkg::PH_COUNT: begin
          rec_len = b;
          byte_idx = '0;
          ph = ihx_pkg::PH_OFFSET;
          return 1'b0;
        end
        ihx_pkg::PH_OFFSET: begin
          rec_off = {rec_off[7:0], b};
          if (byte_idx == 0) begin
            byte_idx = 8'd1;
          end else begin
            byte_idx = '0;
            ph = ihx_pkg::PH_TYPE;
          end
          return 1'b0;
        end
        ihx_pkg::PH_TYPE: begin
          rec_type = b;
          ph = (rec_len != 0) ? ihx_pkg::PH_DATA : ihx_pkg::PH_CHECK;
          return 1'b0;
        end
        ihx_pkg::PH_DATA: begin
          idx = {24'd0, byte_idx};
          byte_idx = byte_idx + 8'd1;
          if (idx + 1 >= rec_len) ph = ihx_pkg::PH_CHECK;
          if (rec_type == ihx_pkg::REC_UPPER && rec_len == ihx_pkg::UPPER_LEN)
            upper_next = {upper_next[7:0], b};
          if (rec_type == ihx_pkg::REC_DATA && !bad_data)
            return report(ihx_pkg::KIND_DATA,
                          {upper, 16'h0000} + {16'h0000, rec_off} + idx, b, r);
          return 1'b0;
        end
        default: begin
          ph = ihx_pkg::PH_TRAIL;
          if (bad_data) return halt_with(ihx_pkg::KIND_BAD_DATA, r);
          if (bad_check || sum != 0) return halt_with(ihx_pkg::KIND_CHECKSUM, r);
          if (rec_type == ihx_pkg::REC_EOF) begin
            done = 1'b1;
            return report(ihx_pkg::KIND_END, '0, '0, r);
          end
          if (rec_type == ihx_pkg::REC_UPPER && rec_len == ihx_pkg::UPPER_LEN) upper = upper_next;
          return report(ihx_pkg::KIND_OK, '0, '0, r);
        end
      endcase
    endfunction

    function void note_input(logic [1:0] act, logic [7:0] c);
      hex_result_t r;
      if (decode_step(act, c, r)) pending_results.push_back(r);
    endfunction

    function void note_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [2:0] kind, logic [55:0] data);
      hex_result_t want;
      if (pending_results.size() == 0) begin
        note_fail($sformatf("unexpected result kind %0d tdata %h", kind, data));
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind || data[31:0] !== want.addr ||
          data[39:32] !== want.data_byte || data[55:40] !== want.line_number)
        note_fail($sformatf("want kind %0d addr %h byte %h line %0d, got kind %0d addr %h byte %h line %0d",
                            want.kind, want.addr, want.data_byte, want.line_number,
                            kind, data[31:0], data[39:32], data[55:40]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // character[7:0]
  logic [1:0]  s_tuser = '0;    // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;         // address[31:0], data_byte[39:32], line_number[55:40]
  logic [2:0]  m_tuser;         // kind[2:0]

  hex_scoreboard sb = new();

  // Pending stimulus: {action, character} per transaction
  logic [9:0] text_q[$];
  int  sent_count = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;      // no idling on either side
  bit  src_calm = 1'b0;   // long stretches without source gaps
  bit  sink_calm = 1'b0;  // long stretches without sink stalls
  int  sink_hold = 0;

  intel_hex_stream_decoder #(
    .LINE_NUMBER_BITS(LINE_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: both sides sampled at the rising edge, input noted before the
  // result check so an expectation is always queued ahead of its result.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Result sink: random stall bursts, none when quiet or in a calm stretch.
  always @(negedge clk) begin
    if (rst || quiet || sink_calm) begin
      m_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
      sink_hold <= $urandom_range(0, 15);
    end else begin
      m_tready <= 1'b1;
    end
    if ($urandom_range(0, 299) == 0) sink_calm <= ~sink_calm;
  end

  // Watchdog: a run that stops moving is a failure.
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("[intel_hex_stream_decoder] ERROR");
    $finish;
  end

  // Drive one transaction; called at a falling edge, returns at a falling edge.
  task automatic send_item(logic [1:0] act, logic [7:0] ch);
    if ($urandom_range(0, 299) == 0) src_calm = ~src_calm;
    if (!quiet && !src_calm && $urandom_range(0, 11) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= ch;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent_count++;
  endtask

  // Send everything queued, with the odd unused-action transaction mixed in.
  task automatic flush_text();
    logic [9:0] it;
    while (text_q.size() != 0) begin
      it = text_q.pop_front();
      if ($urandom_range(0, 63) == 0) send_item(ACT_UNUSED, 8'($urandom_range(0, 255)));
      send_item(it[9:8], it[7:0]);
    end
  endtask

  function automatic void push_char(logic [7:0] ch);
    text_q.push_back({ihx_pkg::ACT_CHAR, ch});
  endfunction

  function automatic void push_ctl(logic [1:0] act);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    text_q.push_back({act, junk});
  endfunction

  // Two hex digits, letters in either case.
  function automatic void push_hex_byte(logic [7:0] v);
    logic [3:0] n;
    for (int i = 1; i >= 0; i--) begin
      n = v[i*4 +: 4];
      if (n < 10) push_char("0" + {4'h0, n});
      else if ($urandom_range(0, 1) != 0) push_char("A" + {4'h0, n} - 8'd10);
      else push_char("a" + {4'h0, n} - 8'd10);
    end
  endfunction

  // ':' count offset type data checksum; sum_err skews the checksum.
  function automatic void push_record(int len, logic [15:0] off, logic [7:0] typ,
                                      logic [15:0] up_val, logic [7:0] sum_err, int fill);
    logic [7:0] sum;
    logic [7:0] b;
    sum = len[7:0] + off[15:8] + off[7:0] + typ;
    push_char(ihx_pkg::CH_COLON);
    push_hex_byte(len[7:0]);
    push_hex_byte(off[15:8]);
    push_hex_byte(off[7:0]);
    push_hex_byte(typ);
    for (int i = 0; i < len; i++) begin
      if (typ == ihx_pkg::REC_UPPER && len == 2) b = (i == 0) ? up_val[15:8] : up_val[7:0];
      else if (fill >= 0) b = fill[7:0];
      else b = 8'($urandom_range(0, 255));
      sum = sum + b;
      push_hex_byte(b);
    end
    push_hex_byte(8'h00 - sum + sum_err);
  endfunction

  function automatic void push_lead();
    logic [7:0] blanks [4] = '{ihx_pkg::CH_SPACE, ihx_pkg::CH_TAB,
                               ihx_pkg::CH_VT, ihx_pkg::CH_FF};
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
      push_char(blanks[$urandom_range(0, 3)]);
  endfunction

  // CR, LF or CR-LF
  function automatic void push_eol();
    case ($urandom_range(0, 2))
      0: push_char(ihx_pkg::CH_CR);
      1: push_char(ihx_pkg::CH_LF);
      default: begin
        push_char(ihx_pkg::CH_CR);
        push_char(ihx_pkg::CH_LF);
      end
    endcase
  endfunction

  // Complete line, now and then with junk after the checksum.
  function automatic void good_line(int len, logic [15:0] off, logic [7:0] typ,
                                    logic [15:0] up_val = 16'h0000, int fill = -1);
    logic [7:0] ch;
    push_lead();
    push_record(len, off, typ, up_val, 8'h00, fill);
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        ch = 8'($urandom_range(0, 255));
        if (ch != ihx_pkg::CH_CR && ch != ihx_pkg::CH_LF) push_char(ch);
      end
    end
    push_eol();
  endfunction

  initial begin
    int r;
    int base;
    int k;
    logic [7:0] typ;
    logic [7:0] ch;
    logic [15:0] off;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // empty data record after blanks, CR-LF end
    push_char(ihx_pkg::CH_SPACE);
    push_char(ihx_pkg::CH_TAB);
    push_record(0, 16'h0000, ihx_pkg::REC_DATA, 16'h0000, 8'h00, -1);
    push_char(ihx_pkg::CH_CR);
    push_char(ihx_pkg::CH_LF);
    // blank lines, with and without whitespace
    push_char(ihx_pkg::CH_LF);
    push_char(ihx_pkg::CH_VT);
    push_char(ihx_pkg::CH_FF);
    push_char(ihx_pkg::CH_CR);
    push_char(ihx_pkg::CH_CR);
    // extreme bytes and offsets
    good_line(2, 16'h0000, ihx_pkg::REC_DATA, 16'h0000, 0);
    good_line(2, 16'hFFFF, ihx_pkg::REC_DATA, 16'h0000, 255);
    // top upper address, then a record that runs past 2^32
    good_line(2, 16'h0000, ihx_pkg::REC_UPPER, 16'hFFFF);
    push_record(32, 16'hFFF0, ihx_pkg::REC_DATA, 16'h0000, 8'h00, -1);
    push_char("z");
    push_char(ihx_pkg::CH_SPACE);
    push_char(ihx_pkg::CH_CR);
    // type 4 with the wrong count and other types are acknowledged only
    good_line(1, 16'h1234, ihx_pkg::REC_UPPER);
    good_line(3, 16'h0010, 8'h05);
    good_line(0, 16'h0000, 8'hFF);
    // longest record
    good_line(255, 16'h0000, ihx_pkg::REC_DATA);
    // unused action in the middle of a record
    base = text_q.size();
    push_record(2, 16'h4000, ihx_pkg::REC_DATA, 16'h0000, 8'h00, -1);
    text_q.insert(base + 6, {ACT_UNUSED, 8'h3A});
    push_eol();
    // end of stream at a line boundary, then everything is ignored
    push_ctl(ihx_pkg::ACT_END);
    good_line(1, 16'h0000, ihx_pkg::REC_DATA);
    push_ctl(ihx_pkg::ACT_END);
    push_ctl(ihx_pkg::ACT_RESTART);
    // end record stops decoding
    good_line(0, 16'h0000, ihx_pkg::REC_EOF);
    good_line(1, 16'h0000, ihx_pkg::REC_DATA);
    push_ctl(ihx_pkg::ACT_RESTART);
    // checksum value off by one
    push_record(1, 16'h0020, ihx_pkg::REC_DATA, 16'h0000, 8'h01, -1);
    push_eol();
    push_ctl(ihx_pkg::ACT_RESTART);
    // bad data digit outranks a bad checksum digit
    base = text_q.size();
    push_record(2, 16'h0100, ihx_pkg::REC_DATA, 16'h0000, 8'h00, -1);
    text_q[base + 9] = {ihx_pkg::ACT_CHAR, 8'h67};
    text_q[base + 13] = {ihx_pkg::ACT_CHAR, 8'h78};
    push_eol();
    push_ctl(ihx_pkg::ACT_RESTART);
    // bad checksum digit alone
    base = text_q.size();
    push_record(1, 16'h0100, ihx_pkg::REC_DATA, 16'h0000, 8'h00, -1);
    text_q[base + 12] = {ihx_pkg::ACT_CHAR, 8'h3F};
    push_eol();
    push_ctl(ihx_pkg::ACT_RESTART);
    // non-hex digit in the offset
    base = text_q.size();
    push_record(1, 16'h0100, ihx_pkg::REC_DATA, 16'h0000, 8'h00, -1);
    text_q[base + 3] = {ihx_pkg::ACT_CHAR, 8'h47};
    push_eol();
    push_ctl(ihx_pkg::ACT_RESTART);
    // short records: line end, end of stream, whitespace
    push_record(4, 16'h0200, ihx_pkg::REC_DATA, 16'h0000, 8'h00, -1);
    repeat (5) void'(text_q.pop_back());
    push_char(ihx_pkg::CH_LF);
    push_ctl(ihx_pkg::ACT_RESTART);
    push_record(1, 16'h0200, ihx_pkg::REC_DATA, 16'h0000, 8'h00, -1);
    void'(text_q.pop_back());
    push_ctl(ihx_pkg::ACT_END);
    push_ctl(ihx_pkg::ACT_RESTART);
    base = text_q.size();
    push_record(2, 16'h0200, ihx_pkg::REC_DATA, 16'h0000, 8'h00, -1);
    text_q[base + 10] = {ihx_pkg::ACT_CHAR, ihx_pkg::CH_SPACE};
    push_eol();
    push_ctl(ihx_pkg::ACT_RESTART);
    // bad start
    push_char(ihx_pkg::CH_SPACE);
    push_char("X");
    push_ctl(ihx_pkg::ACT_RESTART);
    // restart in the middle of a record, then a clean line 1
    push_record(3, 16'h0300, ihx_pkg::REC_DATA, 16'h0000, 8'h00, -1);
    repeat (4) void'(text_q.pop_back());
    push_ctl(ihx_pkg::ACT_RESTART);
    good_line(1, 16'h0300, ihx_pkg::REC_DATA);
    flush_text();

    // ---- random part; the closing stretch runs with no idling ----
    while (sent_count < ITEM_COUNT) begin
      if (sent_count > ITEM_COUNT - QUIET_ITEMS) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // run of good lines; state carries over between them
        repeat ($urandom_range(1, 4)) begin
          k = $urandom_range(0, 99);
          off = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 8))
                                            : 16'($urandom_range(0, 65535));
          if (k < 70) begin
            good_line(($urandom_range(0, 19) == 0) ? $urandom_range(16, 40)
                                                    : $urandom_range(0, 8), off,
                      ihx_pkg::REC_DATA);
          end else if (k < 82) begin
            good_line(2, off, ihx_pkg::REC_UPPER,
                      ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
          end else if (k < 88) begin
            good_line($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(3, 6),
                      off, ihx_pkg::REC_UPPER);
          end else if (k < 96) begin
            typ = 8'($urandom_range(2, 255));
            if (typ == ihx_pkg::REC_UPPER) typ = 8'h03;
            good_line($urandom_range(0, 4), off, typ);
          end else begin
            push_lead();
            push_eol();
          end
        end
        if ($urandom_range(0, 7) == 0) begin
          good_line(0, 16'($urandom_range(0, 65535)), ihx_pkg::REC_EOF);
          if ($urandom_range(0, 1) != 0) good_line(1, 16'h0000, ihx_pkg::REC_DATA);
          if ($urandom_range(0, 1) != 0) push_ctl(ihx_pkg::ACT_END);
          push_ctl(ihx_pkg::ACT_RESTART);
        end
      end else if (r < 70) begin
        // broken line: spoiled character, truncation or bad start
        push_lead();
        base = text_q.size();
        push_record($urandom_range(0, 6), 16'($urandom_range(0, 65535)),
                    ($urandom_range(0, 3) == 0) ? ihx_pkg::REC_UPPER : ihx_pkg::REC_DATA,
                    16'($urandom_range(0, 65535)),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00, -1);
        k = $urandom_range(0, 2);
        if (k == 0) begin
          ch = 8'($urandom_range(0, 255));
          text_q[base + $urandom_range(1, text_q.size() - base - 1)] = {ihx_pkg::ACT_CHAR, ch};
          push_eol();
        end else if (k == 1) begin
          repeat ($urandom_range(1, text_q.size() - base - 1)) void'(text_q.pop_back());
          case ($urandom_range(0, 3))
            0: push_char(ihx_pkg::CH_LF);
            1: push_char(ihx_pkg::CH_CR);
            2: push_char(($urandom_range(0, 1) != 0) ? ihx_pkg::CH_TAB : ihx_pkg::CH_SPACE);
            default: push_ctl(ihx_pkg::ACT_END);
          endcase
        end else begin
          while (text_q.size() > base) void'(text_q.pop_back());
          do ch = 8'($urandom_range(0, 255));
          while (ch == ihx_pkg::CH_COLON || ch == ihx_pkg::CH_SPACE || ch == ihx_pkg::CH_TAB ||
                 ch == ihx_pkg::CH_VT || ch == ihx_pkg::CH_FF || ch == ihx_pkg::CH_CR ||
                 ch == ihx_pkg::CH_LF);
          push_char(ch);
        end
        if ($urandom_range(0, 1) != 0) good_line(1, 16'h0000, ihx_pkg::REC_DATA);
        if ($urandom_range(0, 3) == 0) push_ctl(ihx_pkg::ACT_END);
        push_ctl(ihx_pkg::ACT_RESTART);
      end else if (r < 80) begin
        // end of stream between lines
        push_ctl(ihx_pkg::ACT_END);
        if ($urandom_range(0, 1) != 0) push_char(8'($urandom_range(0, 255)));
        push_ctl(ihx_pkg::ACT_RESTART);
      end else if (r < 88) begin
        // record cut short by a restart
        push_lead();
        base = text_q.size();
        push_record($urandom_range(0, 6), 16'($urandom_range(0, 65535)), ihx_pkg::REC_DATA,
                    16'h0000, 8'h00, -1);
        repeat ($urandom_range(1, text_q.size() - base - 1)) void'(text_q.pop_back());
        push_ctl(ihx_pkg::ACT_RESTART);
      end else begin
        // raw noise over all actions and characters
        repeat ($urandom_range(1, 8)) begin
          ch = 8'($urandom_range(0, 255));
          text_q.push_back({2'($urandom_range(0, 3)), ch});
        end
        push_ctl(ihx_pkg::ACT_RESTART);
      end
      flush_text();
    end
    s_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending_results.size() == 0)
      $display("[intel_hex_stream_decoder] OK");
    else
      $display("[intel_hex_stream_decoder] ERROR");
    $finish;
  end

endmodule
